FILE: src/rrob_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrob_pkg
// shared types and constants for the register rename reorder buffer
// ---------------------------------------------------------------------------
package rrob_pkg;

    localparam int ROB_DEPTH  = 64;
    localparam int ARCH_REGS  = 67;
    localparam int TAG_W      = $clog2(ROB_DEPTH);
    localparam int REG_W      = 7;
    localparam int CNT_W      = $clog2(ROB_DEPTH + 1);
    localparam int MAX_RES    = 8;
    localparam int Q_DEPTH    = 2;

    localparam logic [1:0] OP_RENAME   = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_RETIRE   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTHING = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       has_dest;
        logic [6:0] dest_reg;
        logic       has_src1;
        logic [6:0] src1_reg;
        logic       has_src2;
        logic [6:0] src2_reg;
        logic [5:0] done_tag;
    } rrob_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] rob_tag;
        logic       src1_in_rob;
        logic [5:0] src1_tag;
        logic       src1_ready;
        logic       src2_in_rob;
        logic [5:0] src2_tag;
        logic       src2_ready;
        logic       retired_has_dest;
        logic [6:0] retired_dest;
        logic       last;
    } rrob_out_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic       dest_ok;
        logic [6:0] dest_reg;
        logic       src1_ok;
        logic [6:0] src1_reg;
        logic       src2_ok;
        logic [6:0] src2_reg;
        logic [5:0] done_tag;
        logic [3:0] limit;
    } rrob_cmd_t;

endpackage

FILE: src/register_rename_reorder_buffer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// register_rename_reorder_buffer
// rename map table with a circular reorder buffer
// ---------------------------------------------------------------------------
// channel   ports                    payload
// input     s_valid / s_ready        rrob_in_t s_data
// result    m_valid / m_ready        rrob_out_t m_data
// config    cfg_we / cfg_wdata       retire width
//
// from input beat to result beat: rename passes the idle, lookup and rename
// states, complete and unused opcode idle and complete, nothing to retire idle
// and check, retire idle, check and map to its first beat and check and map for
// each further beat, up to the retire width; map and entry reads are registered
// after reset the back end clears the valid bit of every map entry in turn while
// the two entry command queue takes beats; reset is synchronous
// a stalled result beat holds the back end; the queue then fills and drops s_ready
module register_rename_reorder_buffer import rrob_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  rrob_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rrob_out_t m_data
);
    logic      q_valid, q_ready;
    rrob_cmd_t q_cmd;

    rrob_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_cmd
    );

    rrob_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready, .m_data
    );
endmodule

FILE: src/rrob_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrob_front
// accepts input beats, range checks register numbers, queues commands
// ---------------------------------------------------------------------------
module rrob_front import rrob_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  rrob_in_t  s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output rrob_cmd_t q_cmd
);
    logic [3:0] width_reg;
    rrob_cmd_t  q_mem_reg [Q_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    rrob_cmd_t  cmd;
    logic       push, pop;

    // retire width register, clamped on use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 4'd1;
        end else if (cfg_we) begin
            width_reg <= cfg_wdata;
        end
    end

    // classify the beat
    always_comb begin
        cmd.op       = s_data.op;
        cmd.dest_ok  = s_data.has_dest && (s_data.dest_reg < REG_W'(ARCH_REGS));
        cmd.dest_reg = s_data.dest_reg;
        cmd.src1_ok  = s_data.has_src1 && (s_data.src1_reg < REG_W'(ARCH_REGS));
        cmd.src1_reg = s_data.src1_reg;
        cmd.src2_ok  = s_data.has_src2 && (s_data.src2_reg < REG_W'(ARCH_REGS));
        cmd.src2_reg = s_data.src2_reg;
        cmd.done_tag = s_data.done_tag;
        if (width_reg == 4'd0) begin
            cmd.limit = 4'd1;
        end else if (width_reg > 4'(MAX_RES)) begin
            cmd.limit = 4'(MAX_RES);
        end else begin
            cmd.limit = width_reg;
        end
    end

    assign s_ready = (cnt_reg != 2'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = q_mem_reg[rp_reg];

    // command queue
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wp_reg] <= cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: src/rrob_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrob_back
// rename map, reorder buffer and retire sequencer with output register
// ---------------------------------------------------------------------------
module rrob_back import rrob_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  rrob_cmd_t q_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output rrob_out_t m_data
);
    typedef enum logic [6:0] {
        B_INIT = 7'b0000001,
        B_IDLE = 7'b0000010,
        B_LOOK = 7'b0000100,
        B_REN  = 7'b0001000,
        B_CPL  = 7'b0010000,
        B_RCHK = 7'b0100000,
        B_RMAP = 7'b1000000
    } bstate_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } map_ent_t;

    typedef struct packed {
        logic             has_dest;
        logic [REG_W-1:0] dest;
    } ent_info_t;

    // storage
    map_ent_t         map_mem [ARCH_REGS];
    ent_info_t        info_mem [ROB_DEPTH];
    logic             rdy_mem [ROB_DEPTH];

    // control registers
    bstate_t          state_reg, state_next;
    rrob_cmd_t        cmd_reg;
    logic [TAG_W-1:0] head_reg, head_next;
    logic [TAG_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [3:0]       n_reg, n_next;
    logic [REG_W-1:0] clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;
    rrob_out_t        out_reg, out_next;

    // registered read data
    map_ent_t         map_a_reg, map_b_reg;
    logic             rdy_a_reg, rdy_b_reg;
    ent_info_t        info_reg;

    // memory port controls
    logic             out_free, emit;
    logic             map_re, map_we, rdy_re, rdy_we, info_re, info_we;
    logic [REG_W-1:0] map_ra, map_rb, map_wa;
    map_ent_t         map_wd;
    logic [TAG_W-1:0] rdy_ra, rdy_rb, rdy_wa, info_ra;
    logic             rdy_wd;
    ent_info_t        info_wd;
    logic [TAG_W-1:0] hnext, hnext2;
    logic             rob_full, ret_last;

    function automatic logic [TAG_W-1:0] next_tag(input logic [TAG_W-1:0] p);
        return (p == TAG_W'(ROB_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign q_ready  = (state_reg == B_IDLE);
    assign hnext    = next_tag(head_reg);
    assign hnext2   = next_tag(hnext);
    assign rob_full = (occ_reg == CNT_W'(ROB_DEPTH));
    // this retire beat ends the request when the count is used up or the next
    // entry is absent or not ready
    assign ret_last = (n_reg + 4'd1 >= cmd_reg.limit) || (occ_reg == CNT_W'(1))
                      || !rdy_b_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        emit       = 1'b0;
        map_re     = 1'b0;
        map_ra     = '0;
        map_rb     = '0;
        map_we     = 1'b0;
        map_wa     = '0;
        map_wd     = '0;
        rdy_re     = 1'b0;
        rdy_ra     = head_reg;
        rdy_rb     = hnext;
        rdy_we     = 1'b0;
        rdy_wa     = '0;
        rdy_wd     = 1'b0;
        info_re    = 1'b0;
        info_ra    = head_reg;
        info_we    = 1'b0;
        info_wd    = '0;
        unique case (state_reg)
            B_INIT: begin
                // clear map valid bits one entry per cycle
                map_we   = 1'b1;
                map_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == REG_W'(ARCH_REGS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    n_next  = '0;
                    map_re  = 1'b1;
                    map_ra  = q_cmd.src1_ok ? q_cmd.src1_reg : '0;
                    map_rb  = q_cmd.src2_ok ? q_cmd.src2_reg : '0;
                    rdy_re  = 1'b1;
                    info_re = 1'b1;
                    unique case (q_cmd.op)
                        OP_RENAME: state_next = B_LOOK;
                        OP_RETIRE: state_next = B_RCHK;
                        default:   state_next = B_CPL;
                    endcase
                end
            end
            B_LOOK: begin
                // producer ready bits
                rdy_re     = 1'b1;
                rdy_ra     = map_a_reg.tag;
                rdy_rb     = map_b_reg.tag;
                state_next = B_REN;
            end
            B_REN: begin
                if (out_free) begin
                    emit          = 1'b1;
                    out_next      = '0;
                    out_next.last = 1'b1;
                    if (rob_full) begin
                        out_next.status = ST_FULL;
                    end else begin
                        out_next.status     = ST_DONE;
                        out_next.rob_tag    = tail_reg;
                        out_next.src1_ready = 1'b1;
                        out_next.src2_ready = 1'b1;
                        if (cmd_reg.src1_ok && map_a_reg.valid) begin
                            out_next.src1_in_rob = 1'b1;
                            out_next.src1_tag    = map_a_reg.tag;
                            out_next.src1_ready  = rdy_a_reg;
                        end
                        if (cmd_reg.src2_ok && map_b_reg.valid) begin
                            out_next.src2_in_rob = 1'b1;
                            out_next.src2_tag    = map_b_reg.tag;
                            out_next.src2_ready  = rdy_b_reg;
                        end
                        info_we          = 1'b1;
                        info_wd.has_dest = cmd_reg.dest_ok;
                        info_wd.dest     = cmd_reg.dest_ok ? cmd_reg.dest_reg : '0;
                        rdy_we           = 1'b1;
                        rdy_wa           = tail_reg;
                        rdy_wd           = 1'b0;
                        if (cmd_reg.dest_ok) begin
                            map_we       = 1'b1;
                            map_wa       = cmd_reg.dest_reg;
                            map_wd.valid = 1'b1;
                            map_wd.tag   = tail_reg;
                        end
                        tail_next = next_tag(tail_reg);
                        occ_next  = occ_reg + 1'b1;
                    end
                    state_next = B_IDLE;
                end
            end
            B_CPL: begin
                if (out_free) begin
                    emit          = 1'b1;
                    out_next      = '0;
                    out_next.last = 1'b1;
                    if (cmd_reg.op == OP_COMPLETE) begin
                        out_next.rob_tag = cmd_reg.done_tag;
                        rdy_we           = 1'b1;
                        rdy_wa           = cmd_reg.done_tag;
                        rdy_wd           = 1'b1;
                    end
                    state_next = B_IDLE;
                end
            end
            B_RCHK: begin
                if (occ_reg == '0 || !rdy_a_reg) begin
                    if (out_free) begin
                        emit            = 1'b1;
                        out_next        = '0;
                        out_next.status = ST_NOTHING;
                        out_next.last   = 1'b1;
                        state_next      = B_IDLE;
                    end
                end else begin
                    // map entry of the retiring destination
                    map_re     = 1'b1;
                    map_ra     = info_reg.dest;
                    state_next = B_RMAP;
                end
            end
            B_RMAP: begin
                if (out_free) begin
                    emit                      = 1'b1;
                    out_next                  = '0;
                    out_next.status           = ST_DONE;
                    out_next.rob_tag          = head_reg;
                    out_next.retired_has_dest = info_reg.has_dest;
                    out_next.retired_dest     = info_reg.dest;
                    out_next.last             = ret_last;
                    if (info_reg.has_dest && map_a_reg.valid && map_a_reg.tag == head_reg) begin
                        map_we = 1'b1;
                        map_wa = info_reg.dest;
                    end
                    head_next = hnext;
                    occ_next  = occ_reg - 1'b1;
                    n_next    = n_reg + 4'd1;
                    if (ret_last) begin
                        state_next = B_IDLE;
                    end else begin
                        rdy_re     = 1'b1;
                        rdy_ra     = hnext;
                        rdy_rb     = hnext2;
                        info_re    = 1'b1;
                        info_ra    = hnext;
                        state_next = B_RCHK;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // map table
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            map_a_reg <= map_mem[map_ra];
            map_b_reg <= map_mem[map_rb];
        end
    end

    // entry ready bits
    always_ff @(posedge aclk) begin
        if (rdy_we) begin
            rdy_mem[rdy_wa] <= rdy_wd;
        end
        if (rdy_re) begin
            rdy_a_reg <= rdy_mem[rdy_ra];
            rdy_b_reg <= rdy_mem[rdy_rb];
        end
    end

    // entry destinations
    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[tail_reg] <= info_wd;
        end
        if (info_re) begin
            info_reg <= info_mem[info_ra];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_INIT;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            n_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            n_reg         <= n_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and result beat
    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
        end
        out_reg <= out_next;
    end
endmodule

FILE: src/rrob_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrob_checker
// port level checks for the rename reorder buffer
// ---------------------------------------------------------------------------
module rrob_checker import rrob_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input rrob_out_t m_data
);
    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed under stall");

    // full stall carries no tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.last && m_data.rob_tag == '0)
        else $error("bad full result");

    // nothing retired is a single final beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NOTHING |-> m_data.last && !m_data.retired_has_dest)
        else $error("bad empty retire result");

    // no result out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind register_rename_reorder_buffer rrob_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// checks the rename map and reorder buffer against a predictor of its own
// ---------------------------------------------------------------------------
// directed beats cover source lookups, out of range registers, completion
// of free entries, empty and partial retires and the unused opcode. Random
// phases then run rename, complete and retire traffic under several retire
// widths. One phase holds the result side off and then renames until the buffer fills up.
// Every result beat is compared field by field with the oldest prediction.
module tb;
    import rrob_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 12;

    // rename predictor and result scoreboard
    class rename_scoreboard;
        bit         map_v [ARCH_REGS];
        bit [5:0]   map_t [ARCH_REGS];
        bit         ent_hd [ROB_DEPTH];
        bit [6:0]   ent_d [ROB_DEPTH];
        bit         ent_rdy [ROB_DEPTH];
        int         head;
        int         tail;
        int         occ;
        bit [3:0]   width;
        rrob_out_t  exp_q [$];
        int         errors;

        function new();
            head = 0;
            tail = 0;
            occ = 0;
            width = 4'd1;
            errors = 0;
            foreach (map_v[i]) map_v[i] = 1'b0;
            foreach (ent_rdy[i]) ent_rdy[i] = 1'b0;
        endfunction

        function void add_exp(rrob_out_t r);
            exp_q.insert(exp_q.size(), r);
        endfunction

        // {in_rob, tag, ready} for one source
        function logic [7:0] lookup_src(logic present, logic [6:0] r);
            if (present && r < ARCH_REGS && map_v[r])
                return {1'b1, map_t[r], ent_rdy[map_t[r]]};
            return {1'b0, 6'd0, 1'b1};
        endfunction

        function void note_input(rrob_in_t it);
            rrob_out_t r;
            int        lim;
            int        n;
            int        t;
            bit        dv;
            r = '0;
            case (it.op)
                OP_RENAME: begin
                    if (occ >= ROB_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        t = tail;
                        dv = it.has_dest && it.dest_reg < ARCH_REGS;
                        {r.src1_in_rob, r.src1_tag, r.src1_ready} =
                            lookup_src(it.has_src1, it.src1_reg);
                        {r.src2_in_rob, r.src2_tag, r.src2_ready} =
                            lookup_src(it.has_src2, it.src2_reg);
                        ent_hd[t] = dv;
                        ent_d[t] = dv ? it.dest_reg : 7'd0;
                        ent_rdy[t] = 1'b0;
                        if (dv) begin
                            map_t[it.dest_reg] = t[5:0];
                            map_v[it.dest_reg] = 1'b1;
                        end
                        tail = (t + 1) % ROB_DEPTH;
                        occ++;
                        r.status = ST_DONE;
                        r.rob_tag = t[5:0];
                    end
                    r.last = 1'b1;
                    add_exp(r);
                end
                OP_COMPLETE: begin
                    ent_rdy[it.done_tag] = 1'b1;
                    r.rob_tag = it.done_tag;
                    r.last = 1'b1;
                    add_exp(r);
                end
                OP_RETIRE: begin
                    lim = (width == 0) ? 1 : (width > MAX_RES) ? MAX_RES : width;
                    n = 0;
                    while (n < lim && occ > 0 && ent_rdy[head]) begin
                        r = '0;
                        t = head;
                        if (ent_hd[t] && map_v[ent_d[t]] && map_t[ent_d[t]] == t)
                            map_v[ent_d[t]] = 1'b0;
                        r.status = ST_DONE;
                        r.rob_tag = t[5:0];
                        r.retired_has_dest = ent_hd[t];
                        r.retired_dest = ent_d[t];
                        head = (t + 1) % ROB_DEPTH;
                        occ--;
                        n++;
                        r.last = !(n < lim && occ > 0 && ent_rdy[head]);
                        add_exp(r);
                    end
                    if (n == 0) begin
                        r.status = ST_NOTHING;
                        r.last = 1'b1;
                        add_exp(r);
                    end
                end
                default: begin
                    r.last = 1'b1;
                    add_exp(r);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task cmp(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(rrob_out_t got);
            rrob_out_t e;
            if (exp_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = exp_q.pop_front();
            cmp("status", got.status, e.status);
            cmp("rob_tag", got.rob_tag, e.rob_tag);
            cmp("src1_in_rob", got.src1_in_rob, e.src1_in_rob);
            cmp("src1_tag", got.src1_tag, e.src1_tag);
            cmp("src1_ready", got.src1_ready, e.src1_ready);
            cmp("src2_in_rob", got.src2_in_rob, e.src2_in_rob);
            cmp("src2_tag", got.src2_tag, e.src2_tag);
            cmp("src2_ready", got.src2_ready, e.src2_ready);
            cmp("retired_has_dest", got.retired_has_dest, e.retired_has_dest);
            cmp("retired_dest", got.retired_dest, e.retired_dest);
            cmp("last", got.last, e.last);
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [3:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    rrob_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    rrob_out_t m_data;

    rename_scoreboard sb;
    rrob_in_t dir_q [$];
    bit  no_idle;
    int  hold_seq;
    int  hold_seen;
    int  hold_cnt;
    int  quiet_cnt;

    register_rename_reorder_buffer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_cnt = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("[register_rename_reorder_buffer] ERROR");
            $finish;
        end
    end

    function void add_dir(rrob_in_t it);
        dir_q.insert(dir_q.size(), it);
    endfunction

    function automatic logic [6:0] pick_reg();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(67, 127));
        if ($urandom_range(0, 2) == 0)
            return 7'($urandom_range(0, 66));
        return 7'($urandom_range(0, 7));
    endfunction

    function automatic rrob_in_t mk(logic [1:0] op, logic hd, logic [6:0] d, logic h1,
                                    logic [6:0] r1, logic h2, logic [6:0] r2,
                                    logic [5:0] tag);
        rrob_in_t it;
        it = '{op, hd, d, h1, r1, h2, r2, tag};
        return it;
    endfunction

    // mostly well formed traffic: completes aim at tags in flight
    function automatic rrob_in_t random_item(int rename_pct);
        rrob_in_t it;
        int       p;
        it.has_dest = 1'($urandom_range(0, 1));
        it.has_src1 = 1'($urandom_range(0, 1));
        it.has_src2 = 1'($urandom_range(0, 1));
        it.done_tag = 6'($urandom_range(0, 63));
        it.dest_reg = pick_reg();
        it.src1_reg = pick_reg();
        it.src2_reg = pick_reg();
        p = $urandom_range(0, 99);
        if (p < rename_pct) begin
            it.op = OP_RENAME;
        end else if (p < rename_pct + 35) begin
            it.op = OP_COMPLETE;
            if (sb.occ > 0 && $urandom_range(0, 9) != 0)
                it.done_tag = 6'((sb.head + $urandom_range(0, sb.occ - 1)) % ROB_DEPTH);
        end else if (p < 96) begin
            it.op = OP_RETIRE;
        end else begin
            it.op = 2'd3;
        end
        return it;
    endfunction

    task send_item(rrob_in_t it);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_input(it);
    endtask

    task end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task drain();
        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task write_width(logic [3:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.width = v;
    endtask

    initial begin
        logic [3:0] widths [6];
        int base;
        int cnt;
        sb = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 4'd0;
        s_valid = 1'b0;
        s_data = '0;
        no_idle = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats at the reset retire width
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));       // empty buffer
        add_dir(mk(2'd3, 1, 127, 1, 127, 1, 127, 63));     // unused opcode
        add_dir(mk(OP_RENAME, 1, 5, 0, 5, 0, 0, 0));       // no sources
        add_dir(mk(OP_RENAME, 1, 5, 1, 5, 1, 5, 0));       // source is dest
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 0));
        add_dir(mk(OP_RENAME, 1, 127, 1, 5, 1, 127, 0));   // out of range regs
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 1));
        add_dir(mk(OP_RENAME, 1, 66, 1, 5, 1, 66, 0));
        add_dir(mk(OP_RENAME, 0, 0, 1, 66, 1, 0, 0));      // no dest
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 63));    // free entry
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));       // head not ready
        add_dir(mk(OP_RENAME, 1, 0, 1, 66, 1, 5, 0));
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 2));
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 3));
        add_dir(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 4));
        add_dir(mk(OP_RENAME, 1, 1, 1, 0, 1, 66, 0));
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));
        add_dir(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));
        add_dir(mk(OP_RENAME, 1, 2, 1, 0, 1, 1, 0));
        foreach (dir_q[i]) send_item(dir_q[i]);
        end_burst();

        // fill the buffer, with results held off at first
        drain();
        write_width(4'd8);
        no_idle = 1'b1;
        hold_seq++;
        repeat (80) send_item(random_item(100));
        no_idle = 1'b0;
        base = sb.head;
        cnt = sb.occ;
        for (int j = 0; j < cnt; j++)
            send_item(mk(OP_COMPLETE, 0, 0, 0, 0, 0, 0, 6'((base + j) % ROB_DEPTH)));
        while (sb.occ > 0)
            send_item(mk(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0));
        end_burst();

        // random phases over several retire widths
        widths = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd8, 4'd0};
        widths[5] = 4'($urandom_range(0, 15));
        foreach (widths[i]) begin
            drain();
            write_width(widths[i]);
            no_idle = (i == 2);
            repeat (50) send_item(random_item((i % 2) ? 35 : 45));
            end_burst();
        end
        no_idle = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("[register_rename_reorder_buffer] OK");
        else
            $display("[register_rename_reorder_buffer] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/rrob_pkg.sv
src/rrob_front.sv
src/rrob_back.sv
src/register_rename_reorder_buffer.sv
src/rrob_checker.sv
dv/tb.sv
